// ===== hw/rtl/ssr_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_pkg
// shared constants and types for the slice segment rasterizer
// ---------------------------------------------------------------------------
package ssr_pkg;

   localparam int Res      = 32;
   localparam int PixW     = $clog2(Res);
   localparam int Half     = Res / 2;
   localparam int RootW    = 16;
   localparam int QueueDepth = 2;

   // classified segment handed from front to back
   typedef struct packed {
      logic [7:0]       slice;
      logic [PixW-1:0]  c0;
      logic [PixW-1:0]  r0;
      logic [PixW-1:0]  c1;
      logic [PixW-1:0]  r1;
   } seg_type;

   // clamp a signed pixel value to 0..Res-1
   function automatic logic [PixW-1:0] clamp_pix(input logic signed [RootW+1:0] p);
      logic [PixW-1:0] r;
      if (p < 0) r = '0;
      else if (p > (Res - 1)) r = PixW'(Res - 1);
      else r = p[PixW-1:0];
      return r;
   endfunction

endpackage

// ===== hw/rtl/ssr_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_front
// projects both endpoints onto the slice plane, one bit-pair sqrt per cycle
// ---------------------------------------------------------------------------
module ssr_front (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_push,
   output logic            req_full,
   input  logic [7:0]      slice_index,
   input  logic signed [15:0] start_x,
   input  logic signed [15:0] start_y,
   input  logic signed [15:0] start_z,
   input  logic signed [15:0] end_x,
   input  logic signed [15:0] end_y,
   input  logic signed [15:0] end_z,
   output logic            seg_valid,
   input  logic            seg_ready,
   output ssr_pkg::seg_type seg
);

   localparam int PixW_l = ssr_pkg::PixW;
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StSq   = 3'd1;   // square and sum
   localparam logic [2:0] StRoot = 3'd2;   // sqrt iterations
   localparam logic [2:0] StCol  = 3'd3;   // column from root
   localparam logic [2:0] StOut  = 3'd4;

   logic [2:0]  state_ff, state_in;
   logic        which_ff, which_in;    // 0 start, 1 end
   logic [3:0]  iter_ff, iter_in;
   logic [7:0]  slice_ff;
   logic signed [15:0] sx_ff, sz_ff, ex_ff, ez_ff, sy_ff, ey_ff;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] s_ff, s_in;
   ssr_pkg::seg_type seg_ff, seg_in;

   logic signed [15:0] cx, cz;
   logic [15:0] ax, az;
   logic [31:0] sum_sq;
   logic [31:0] bitv, trial;
   logic        pos;
   logic [PixW_l-1:0] colv;
   logic [PixW_l-1:0] row0, row1;

   assign cx = which_ff ? ex_ff : sx_ff;
   assign cz = which_ff ? ez_ff : sz_ff;
   assign ax = cx[15] ? 16'(-cx) : cx;
   assign az = cz[15] ? 16'(-cz) : cz;
   // operands are stable in StSq, so the squares are taken there
   assign sum_sq = 32'(ax) * 32'(ax) + 32'(az) * 32'(az);
   assign bitv  = 32'd1 << {(4'd15 - iter_ff), 1'b0};
   assign trial = root_ff + bitv;
   assign pos   = (cz > 0) || (cz == 0 && !cx[15]);

   function automatic logic [PixW_l-1:0] row_of(input logic signed [15:0] y);
      logic [16:0] ny;
      logic [PixW_l-1:0] r;
      ny = 17'(-$signed({y[15], y}));
      if (y > 0)
         r = ssr_pkg::clamp_pix(18'(ssr_pkg::Half) + 18'(y[15:8]));
      else
         r = ssr_pkg::clamp_pix(18'(ssr_pkg::Half - 1) - 18'(ny[16:8]));
      return r;
   endfunction

   always_comb begin
      logic [7:0] m;
      m = root_ff[15:8];
      if (pos)
         colv = (s_ff != 0) ? ssr_pkg::clamp_pix(18'(ssr_pkg::Half) + 18'(m))
                            : PixW_l'(ssr_pkg::Half - 1);
      else
         colv = ssr_pkg::clamp_pix(18'(ssr_pkg::Half - 1) - 18'(m));
   end

   assign row0 = row_of(sy_ff);
   assign row1 = row_of(ey_ff);

   always_comb begin
      state_in = state_ff;
      which_in = which_ff;
      iter_in  = iter_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      s_in     = s_ff;
      seg_in   = seg_ff;
      unique case (state_ff)
         StIdle: if (req_push) begin
            state_in = StSq;
            which_in = 1'b0;
         end
         StSq: begin
            s_in    = sum_sq;
            rem_in  = sum_sq;
            root_in = '0;
            iter_in = '0;
            state_in = StRoot;
         end
         StRoot: begin
            if (rem_ff >= trial) begin
               rem_in  = rem_ff - trial;
               root_in = (root_ff >> 1) + bitv;
            end else begin
               root_in = root_ff >> 1;
            end
            iter_in = iter_ff + 4'd1;
            if (iter_ff == 4'd15) state_in = StCol;
         end
         StCol: begin
            if (!which_ff) begin
               seg_in.c0 = colv;
               which_in  = 1'b1;
               state_in  = StSq;
            end else begin
               seg_in.c1 = colv;
               seg_in.r0 = row0;
               seg_in.r1 = row1;
               seg_in.slice = slice_ff;
               state_in  = StOut;
            end
         end
         StOut: if (seg_ready) state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
      end else begin
         state_ff <= state_in;
      end
      which_ff <= which_in;
      iter_ff  <= iter_in;
      rem_ff   <= rem_in;
      root_ff  <= root_in;
      s_ff     <= s_in;
      seg_ff   <= seg_in;
      if (state_ff == StIdle && req_push) begin
         slice_ff <= slice_index;
         sx_ff <= start_x; sy_ff <= start_y; sz_ff <= start_z;
         ex_ff <= end_x;   ey_ff <= end_y;   ez_ff <= end_z;
      end
   end

   assign req_full  = (state_ff != StIdle);
   assign seg_valid = (state_ff == StOut);
   assign seg       = seg_ff;

endmodule

// ===== hw/rtl/ssr_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_queue
// two-entry queue of classified segments between front and back
// ---------------------------------------------------------------------------
module ssr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  ssr_pkg::seg_type wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output ssr_pkg::seg_type rd_data
);

   ssr_pkg::seg_type mem_ff [ssr_pkg::QueueDepth];
   logic             wp_ff, rp_ff;
   logic [1:0]       cnt_ff;
   logic             wr, rd;

   assign wr_ready = (cnt_ff != 2'(ssr_pkg::QueueDepth));
   assign rd_valid = (cnt_ff != 2'd0);
   assign wr = wr_valid && wr_ready;
   assign rd = rd_valid && rd_ready;
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= '0;
      end else begin
         if (wr) wp_ff <= ~wp_ff;
         if (rd) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + 2'(wr) - 2'(rd);
      end
      if (wr) mem_ff[wp_ff] <= wr_data;
   end

endmodule

// ===== hw/rtl/ssr_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// ssr_back
// walks the major axis and rounds the minor axis with a serial divider
// ---------------------------------------------------------------------------
module ssr_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             seg_valid,
   output logic             seg_ready,
   input  ssr_pkg::seg_type seg,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output logic [7:0]       slice_out,
   output logic [ssr_pkg::PixW-1:0] pixel_col,
   output logic [ssr_pkg::PixW-1:0] pixel_row,
   output logic             last_pixel
);

   localparam int PW = ssr_pkg::PixW;
   localparam int NW = 2 * PW + 4;   // numerator width
   localparam int QW = NW;
   localparam int CW = $clog2(NW + 1);
   localparam logic [1:0] StIdle = 2'd0;
   localparam logic [1:0] StDiv  = 2'd1;
   localparam logic [1:0] StOut  = 2'd2;

   logic [1:0]  state_ff, state_in;
   ssr_pkg::seg_type s_ff;
   logic        colmaj_ff;
   logic [PW-1:0] k_ff, hi_ff;
   logic [NW-1:0] num_ff;            // |2n|+d
   logic          neg_ff;
   logic [NW-1:0] rem_ff;
   logic [QW-1:0] quo_ff;
   logic [CW-1:0] cnt_ff;
   logic [PW-1:0] outc_ff, outr_ff;
   logic          outl_ff, full_ff;

   logic signed [PW+1:0] dc, dr, ad, adc, adr;
   logic signed [NW:0]   n;
   logic [NW-1:0] an, d2;
   logic [NW:0]   trial;
   logic [PW-1:0] minor;

   assign dc  = $signed({2'b0, s_ff.c1}) - $signed({2'b0, s_ff.c0});
   assign dr  = $signed({2'b0, s_ff.r1}) - $signed({2'b0, s_ff.r0});
   assign adc = dc[PW+1] ? -dc : dc;
   assign adr = dr[PW+1] ? -dr : dr;
   assign ad  = colmaj_ff ? adc : adr;
   // minor start * major delta + minor delta * (k - major start), times sign
   always_comb begin
      logic signed [NW:0] t;
      if (colmaj_ff) begin
         t = (NW+1)'($signed({2'b0, s_ff.r0})) * (NW+1)'(dc)
           + (NW+1)'(dr) * ((NW+1)'($signed({2'b0, k_ff}))
                          - (NW+1)'($signed({2'b0, s_ff.c0})));
         n = dc[PW+1] ? -t : t;
      end else begin
         t = (NW+1)'($signed({2'b0, s_ff.c0})) * (NW+1)'(dr)
           + (NW+1)'(dc) * ((NW+1)'($signed({2'b0, k_ff}))
                          - (NW+1)'($signed({2'b0, s_ff.r0})));
         n = dr[PW+1] ? -t : t;
      end
   end
   assign an = n[NW] ? NW'(-n) : NW'(n);
   assign d2 = NW'({ad, 1'b0});
   assign trial = {rem_ff, num_ff[NW-1]} - {1'b0, d2};
   // both ends on one pixel: no division, the column is the start column
   assign minor = (ad == 0) ? s_ff.c0 : (neg_ff ? PW'(-quo_ff) : PW'(quo_ff));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         StIdle: if (seg_valid) state_in = StDiv;
         StDiv:  if (cnt_ff == CW'(NW)) state_in = StOut;
         StOut:  if (!full_ff) state_in = (k_ff == hi_ff) ? StIdle : StDiv;
         default: state_in = StIdle;
      endcase
   end

   assign seg_ready = (state_ff == StIdle);

   always_ff @(posedge clock) begin
      logic [PW-1:0] lo_v;
      if (reset) begin
         state_ff <= StIdle;
         full_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == StOut && !full_ff) full_ff <= 1'b1;
         else if (rsp_pop && full_ff) full_ff <= 1'b0;
      end
      unique case (state_ff)
         StIdle: if (seg_valid) begin
            s_ff <= seg;
            cnt_ff <= '0;
            if ((seg.c1 > seg.c0 ? seg.c1 - seg.c0 : seg.c0 - seg.c1) >
                (seg.r1 > seg.r0 ? seg.r1 - seg.r0 : seg.r0 - seg.r1)) begin
               colmaj_ff <= 1'b1;
               lo_v  = (seg.c0 < seg.c1) ? seg.c0 : seg.c1;
               hi_ff <= (seg.c0 < seg.c1) ? seg.c1 : seg.c0;
            end else begin
               colmaj_ff <= 1'b0;
               lo_v  = (seg.r0 < seg.r1) ? seg.r0 : seg.r1;
               hi_ff <= (seg.r0 < seg.r1) ? seg.r1 : seg.r0;
            end
            k_ff <= lo_v;
         end
         StDiv: begin
            if (cnt_ff == '0) begin
               // load (2|n|+d), one quotient bit per following cycle
               num_ff <= NW'({an, 1'b0}) + NW'(ad);
               neg_ff <= n[NW];
               rem_ff <= '0;
               quo_ff <= '0;
            end else if (cnt_ff <= CW'(NW)) begin
               if (!trial[NW]) begin
                  rem_ff <= trial[NW-1:0];
                  quo_ff <= {quo_ff[QW-2:0], 1'b1};
               end else begin
                  rem_ff <= {rem_ff[NW-2:0], num_ff[NW-1]};
                  quo_ff <= {quo_ff[QW-2:0], 1'b0};
               end
               num_ff <= {num_ff[NW-2:0], 1'b0};
            end
            cnt_ff <= cnt_ff + CW'(1);
         end
         StOut: if (!full_ff) begin
            outc_ff <= colmaj_ff ? k_ff : minor;
            outr_ff <= colmaj_ff ? minor : k_ff;
            outl_ff <= (k_ff == hi_ff);
            slice_out <= s_ff.slice;
            k_ff <= k_ff + PW'(1);
            cnt_ff <= '0;
         end
         default: ;
      endcase
   end

   assign rsp_empty  = !full_ff;
   assign pixel_col  = outc_ff;
   assign pixel_row  = outr_ff;
   assign last_pixel = outl_ff;

endmodule

// ===== hw/rtl/slice_segment_pixel_rasterizer.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// slice_segment_pixel_rasterizer
// projects a 3D segment onto its slice plane and emits its DDA pixels
// ---------------------------------------------------------------------------
// from a segment transfer to its first pixel, the front first projects both endpoints
// (two 16-step sqrt passes plus square and column steps), then the back end divides;
// each further pixel is set by the serial divider in the back end
// the front takes a new segment once the queue accepts its last, running ahead via the queue
// reset: synchronous, clears the state machines, queue pointers and output flag
module slice_segment_pixel_rasterizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_slice_index,
   input  logic signed [15:0] req_start_x,
   input  logic signed [15:0] req_start_y,
   input  logic signed [15:0] req_start_z,
   input  logic signed [15:0] req_end_x,
   input  logic signed [15:0] req_end_y,
   input  logic signed [15:0] req_end_z,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [7:0]  rsp_slice_out,
   output logic [4:0]  rsp_pixel_col,
   output logic [4:0]  rsp_pixel_row,
   output logic        rsp_last_pixel
);

   // front to queue transfer
   logic             f_valid, f_ready;
   ssr_pkg::seg_type f_seg;
   // queue to back transfer
   logic             b_valid, b_ready;
   ssr_pkg::seg_type b_seg;

   // endpoint projection
   ssr_front u_front (
      .clock, .reset,
      .req_push, .req_full,
      .slice_index(req_slice_index),
      .start_x(req_start_x), .start_y(req_start_y), .start_z(req_start_z),
      .end_x(req_end_x), .end_y(req_end_y), .end_z(req_end_z),
      .seg_valid(f_valid), .seg_ready(f_ready), .seg(f_seg)
   );

   // decoupling queue
   ssr_queue u_queue (
      .clock, .reset,
      .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_seg),
      .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_seg)
   );

   // pixel walk
   ssr_back u_back (
      .clock, .reset,
      .seg_valid(b_valid), .seg_ready(b_ready), .seg(b_seg),
      .rsp_empty, .rsp_pop,
      .slice_out(rsp_slice_out),
      .pixel_col(rsp_pixel_col),
      .pixel_row(rsp_pixel_row),
      .last_pixel(rsp_last_pixel)
   );

   // a held result stays put until popped
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_pixel_col)
                                    && $stable(rsp_pixel_row)))
      else $error("result changed while waiting");

   // the front holds its segment valid while the queue is full
   a_queue: assert property (@(posedge clock) disable iff (reset)
      (f_valid && !f_ready) |=> f_valid)
      else $error("front dropped a segment");

endmodule
